// ===== src/trm_pkg.sv =====
// ----------------------------------------------------------------------------
// trm_pkg: shared widths, reset values and register indexes
// Constants and types shared by the triangle ring modulator and its carrier NCO.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int SampleW  = 12;               // audio sample width, signed
  localparam int PhaseW   = 32;               // phase accumulator width
  localparam int GainW    = 16;               // Q15 gain width, unsigned
  localparam int CarrierW = 17;               // signed carrier, -32767..+32767
  localparam int FracW    = 15;               // Q15 fraction bits
  localparam int AccW     = 29;               // product / mix accumulator width
  localparam int MixW     = AccW - FracW;     // mix after the Q15 shift
  localparam int TdataW   = 16;               // sample padded to whole bytes
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;
  localparam int CntW     = $clog2(GainW);    // step counter, GainW >= SampleW

  localparam logic [GainW-1:0] DryGainReset = 16'd22937;
  localparam logic [GainW-1:0] WetGainReset = 16'd13107;

  // Triangle is 0..65534, carrier is triangle minus this offset
  localparam logic signed [CarrierW-1:0] CarrierOffset = 17'sd32767;

  // Saturation bounds of the output sample
  localparam logic signed [SampleW-1:0] SampleMax = 12'sd2047;
  localparam logic signed [SampleW-1:0] SampleMin = -12'sd2048;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPhaseStep = 8'd0;
  localparam logic [CfgIdxW-1:0] RegDryGain   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegWetGain   = 8'd2;

  typedef logic signed [CarrierW-1:0] carrier_t;
  typedef logic signed [SampleW-1:0]  sample_t;
  typedef logic signed [AccW-1:0]     acc_t;

endpackage

// ===== src/trm_nco.sv =====
// ----------------------------------------------------------------------------
// trm_nco: phase accumulator with triangle carrier
// Advances a wrapping phase by the step on each strobe and folds the top
// phase bits into a signed triangle carrier.
// ----------------------------------------------------------------------------
module trm_nco (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [trm_pkg::PhaseW-1:0] step_i,
  output trm_pkg::carrier_t          carrier_o
);
  import trm_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [15:0]       top;
  logic [15:0]       tri_w;

  assign phase_d = advance_i ? phase_q + step_i : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Rising half: 2*p; falling half: 2*(32767 - p), with p = top[14:0], where 32767 - p is ~p
  assign top   = phase_q[PhaseW-1 -: 16];
  assign tri_w = top[15] ? {~top[14:0], 1'b0} : {top[14:0], 1'b0};

  assign carrier_o = $signed({1'b0, tri_w}) - CarrierOffset;

endmodule

// ===== src/triangle_ring_modulator.sv =====
// ----------------------------------------------------------------------------
// triangle_ring_modulator: ring modulator with triangle DDS carrier
// Multiplies each audio sample by a triangle carrier and mixes dry and ring
// signals with Q15 gains, using bit-serial shift-and-add multipliers.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  ---------------------------
//  s_axis    in         s_axis_tvalid/tready       tdata[11:0] sample_in
//  m_axis    out        m_axis_tvalid/tready       tdata[11:0] sample_out
//  cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
//  A sample passes from its transfer to its result in the output register
//  through these steps: StRingLoad loads the carrier, 12 serial steps form
//  sample * carrier (one multiplier bit per cycle), StMixInit sets up the
//  mix, 16 serial steps for the dry and wet gains (one gain bit per cycle),
//  and StStore stores the result. Reset clears the phase, the registers to
//  their defaults and the output valid. A stalled output holds the finished
//  sample; the next sample may be taken while it waits.
//
module triangle_ring_modulator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [trm_pkg::TdataW-1:0]   s_axis_tdata,   // [11:0] sample_in
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [trm_pkg::TdataW-1:0]   m_axis_tdata,   // [11:0] sample_out
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [trm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [trm_pkg::CfgDataW-1:0] cfg_data_i
);
  import trm_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StRingLoad,
    StRing,
    StMixInit,
    StMix,
    StStore
  } state_e;

  localparam logic [CntW-1:0] RingLast = CntW'(SampleW - 1);
  localparam logic [CntW-1:0] MixLast  = CntW'(GainW - 1);

  // configuration registers
  logic [PhaseW-1:0] phase_step_q;
  logic [GainW-1:0]  dry_gain_q, wet_gain_q;

  // datapath
  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  sample_t           sample_q, sample_d;
  logic [SampleW-1:0] mplier_q, mplier_d;    // sample bits, shifted out low first
  acc_t              mcand_q, mcand_d;       // carrier, shifted left per step
  acc_t              dry_mc_q, dry_mc_d;     // sample, shifted left per step
  acc_t              wet_mc_q, wet_mc_d;     // ring, shifted left per step
  logic [GainW-1:0]  dry_sh_q, dry_sh_d;
  logic [GainW-1:0]  wet_sh_q, wet_sh_d;
  acc_t              acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  sample_t           out_data_q, out_data_d;

  carrier_t          carrier;
  logic              s_fire;
  sample_t           ring;
  logic signed [MixW-1:0] mixed;
  sample_t           sat;
  acc_t              ring_addend, dry_addend, wet_addend;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      dry_gain_q   <= DryGainReset;
      wet_gain_q   <= WetGainReset;
    end else if (cfg_valid_i) begin
      // drop writes to indexes beyond the register list
      if (cfg_index_i == RegPhaseStep) begin
        phase_step_q <= cfg_data_i[PhaseW-1:0];
      end else if (cfg_index_i == RegDryGain) begin
        dry_gain_q <= cfg_data_i[GainW-1:0];
      end else if (cfg_index_i == RegWetGain) begin
        wet_gain_q <= cfg_data_i[GainW-1:0];
      end
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // phase advances at the input transfer, carrier is read in StRingLoad
  trm_nco u_nco (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s_fire),
    .step_i    (phase_step_q),
    .carrier_o (carrier)
  );

  // ring = (sample * carrier) >>> 15; the value always fits the sample width
  assign ring = acc_q[FracW +: SampleW];

  // mix >>> 15, then clamp when the upper bits are not a sign extension
  assign mixed = acc_q[AccW-1:FracW];
  always_comb begin
    if (mixed[MixW-1:SampleW-1] == '0 || mixed[MixW-1:SampleW-1] == '1) begin
      sat = mixed[SampleW-1:0];
    end else if (mixed[MixW-1]) begin
      sat = SampleMin;
    end else begin
      sat = SampleMax;
    end
  end

  assign ring_addend = mplier_q[0] ? mcand_q : '0;
  assign dry_addend  = dry_sh_q[0] ? dry_mc_q : '0;
  assign wet_addend  = wet_sh_q[0] ? wet_mc_q : '0;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sample_d    = sample_q;
    mplier_d    = mplier_q;
    mcand_d     = mcand_q;
    dry_mc_d    = dry_mc_q;
    wet_mc_d    = wet_mc_q;
    dry_sh_d    = dry_sh_q;
    wet_sh_d    = wet_sh_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    // release the output slot on its transfer
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_fire) begin
          sample_d = s_axis_tdata[SampleW-1:0];
          mplier_d = s_axis_tdata[SampleW-1:0];
          state_d  = StRingLoad;
        end
      end
      StRingLoad: begin
        mcand_d = {{(AccW-CarrierW){carrier[CarrierW-1]}}, carrier};
        acc_d   = '0;
        cnt_d   = '0;
        state_d = StRing;
      end
      StRing: begin
        // two's complement multiplier: the sign bit carries negative weight
        if (cnt_q == RingLast) begin
          acc_d   = acc_q - ring_addend;
          state_d = StMixInit;
        end else begin
          acc_d = acc_q + ring_addend;
        end
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + 1'b1;
      end
      StMixInit: begin
        dry_mc_d = {{(AccW-SampleW){sample_q[SampleW-1]}}, sample_q};
        wet_mc_d = {{(AccW-SampleW){ring[SampleW-1]}}, ring};
        dry_sh_d = dry_gain_q;
        wet_sh_d = wet_gain_q;
        acc_d    = '0;
        cnt_d    = '0;
        state_d  = StMix;
      end
      StMix: begin
        // unsigned gains: add both shifted multiplicands per gain bit
        acc_d    = acc_q + dry_addend + wet_addend;
        dry_mc_d = dry_mc_q <<< 1;
        wet_mc_d = wet_mc_q <<< 1;
        dry_sh_d = dry_sh_q >> 1;
        wet_sh_d = wet_sh_q >> 1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == MixLast) begin
          state_d = StStore;
        end
      end
      StStore: begin
        // hold until the output slot is free
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = sat;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    mplier_q   <= mplier_d;
    mcand_q    <= mcand_d;
    dry_mc_q   <= dry_mc_d;
    wet_mc_q   <= wet_mc_d;
    dry_sh_q   <= dry_sh_d;
    wet_sh_q   <= wet_sh_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TdataW-SampleW){1'b0}}, out_data_q};

endmodule
